### design/bst_pkg.sv
// Shared types and character codes for the bencode stream tokenizer.
package bst_pkg;

  // Width of the nesting depth field and the nesting limit register
  localparam int unsigned DEPTH_W = 6;

  // Reset value of the nesting limit register
  localparam logic [DEPTH_W-1:0] MAX_NESTING_RST = 6'd32;

  // Bencode syntax characters
  localparam logic [7:0] CH_INT   = 8'h69;  // 'i'
  localparam logic [7:0] CH_LIST  = 8'h6C;  // 'l'
  localparam logic [7:0] CH_DICT  = 8'h64;  // 'd'
  localparam logic [7:0] CH_END   = 8'h65;  // 'e'
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_0     = 8'h30;  // '0'
  localparam logic [7:0] CH_9     = 8'h39;  // '9'

  // Parser modes
  typedef enum logic [2:0] {
    MODE_VALUE      = 3'd0,
    MODE_KEY        = 3'd1,
    MODE_INT_START  = 3'd2,
    MODE_INT_DIGITS = 3'd3,
    MODE_LEN        = 3'd4,
    MODE_STR        = 3'd5,
    MODE_DONE       = 3'd6,
    MODE_ERROR      = 3'd7
  } mode_e;

  // Container kinds kept on the nesting stack
  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_LIST     = 2'd1,
    KIND_DICT_KEY = 2'd2,
    KIND_DICT_VAL = 2'd3
  } kind_e;

  // Token event kinds
  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_INT   = 3'd1,
    EV_HDR   = 3'd2,
    EV_BYTE  = 3'd3,
    EV_LIST  = 3'd4,
    EV_DICT  = 3'd5,
    EV_CLOSE = 3'd6,
    EV_ERR   = 3'd7
  } event_e;

  // Error codes
  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_START     = 4'd1,
    ERR_INT       = 4'd2,
    ERR_INT_OVF   = 4'd3,
    ERR_LEN       = 4'd4,
    ERR_LEN_OVF   = 4'd5,
    ERR_KEY       = 4'd6,
    ERR_DEEP      = 4'd7,
    ERR_TRUNCATED = 4'd8
  } err_e;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } bst_in_t;

  // Result word
  typedef struct packed {
    logic [2:0]         event_kind;
    logic signed [63:0] int_value;
    logic [31:0]        string_length;
    logic [7:0]         string_byte;
    logic               is_key;
    logic               last_of_string;
    logic [DEPTH_W-1:0] nesting_depth;
    logic               message_done;
    logic [3:0]         error_code;
  } bst_out_t;

endpackage

### design/bencode_stream_tokenizer_unit.sv
// Streaming bencode tokenizer: one byte in, one token event out.
//
// The block takes one byte per cycle when its input is not stalled, and
// registers one event word per byte, so bytes may follow back to back. Each
// byte is decoded in a single pass between the parser state registers and
// the result register; the longest path is the decimal accumulate (a 68-bit
// shift-add by ten and limit compare) that feeds the integer/length
// register. The innermost container kind sits in a register and the kinds
// below it live in a small stack memory whose registered read port is
// preloaded with the entry under the top, so a close finds the new top ready.
// A two-word output buffer lets a new byte in while a result is stalled.
// The nesting limit register may be written only while the block is idle.
module bencode_stream_tokenizer_unit #(
  parameter int unsigned MAX_DEPTH   = 32,
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_wr_en_i,
  input  logic [5:0]            cfg_wr_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bst_pkg::bst_in_t      in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bst_pkg::bst_out_t     out_data_o
);
  import bst_pkg::*;

  localparam int unsigned LW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned CW = (LW > DEPTH_W) ? LW : DEPTH_W;
  localparam logic [LW-1:0] LVL_ONE   = 1;
  localparam logic [LW-1:0] LVL_THREE = 3;
  localparam logic [LW-1:0] LVL_MAX   = LW'(MAX_DEPTH);
  localparam logic [LENGTH_BITS-1:0] REM_ONE = 1;
  localparam logic [67:0] INT_POS_LIM = 68'h0_7FFF_FFFF_FFFF_FFFF;
  localparam logic [67:0] INT_NEG_LIM = 68'h0_8000_0000_0000_0000;
  localparam logic [67:0] LEN_LIM     = (68'd1 << LENGTH_BITS) - 68'd1;

  // Per-byte decode result
  typedef struct packed {
    event_e kind;
    err_e   err;
    logic   fail;
    logic   push;
    kind_e  push_kind;
    logic   pop;
    logic   fin;
    logic   key_end;
    logic   last;
    logic   int_begin;
    logic   set_neg;
    logic   set_lz;
    logic   mag_digit;
    logic   mag_step;
    logic   len_begin;
    logic   len_key;
    logic   hdr;
    logic   str_byte;
  } act_t;

  // Registers
  logic [DEPTH_W-1:0]     max_nesting_q;
  mode_e                  mode_q, mode_d, mode_step;
  logic [LW-1:0]          level_q, level_d, level_step;
  kind_e                  top_q, top_d, top_after;
  kind_e                  below_q;
  kind_e                  stack_mem [MAX_DEPTH];
  logic [63:0]            mag_q, mag_d;
  logic                   neg_q, neg_d;
  logic                   lz_q, lz_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic                   for_key_q, for_key_d;
  logic                   out_valid_q, skid_valid_q;
  bst_out_t               out_q, skid_q, res_c;

  // Decode helpers
  logic          in_accept, out_take, eod, is_dig, at_limit, eod_fail;
  logic [7:0]    b, dig_diff;
  logic [3:0]    dig_val;
  logic [67:0]   acc_ext, acc_x10;
  logic          int_ovf, len_ovf;
  logic [LW-1:0] lvl_m1, lvl_m3;
  act_t          act;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_take  = out_valid_q && !out_stall_i;
  assign b         = in_data_i.data_byte;
  assign eod       = in_data_i.end_of_data;
  assign is_dig    = b inside {[CH_0:CH_9]};
  assign dig_diff  = b - CH_0;
  assign dig_val   = dig_diff[3:0];

  // Decimal accumulate: value * 10 + digit, checked against the limit
  assign acc_ext = {4'd0, mag_q};
  assign acc_x10 = (acc_ext << 3) + (acc_ext << 1) + {64'd0, dig_val};
  assign int_ovf = acc_x10 > (neg_q ? INT_NEG_LIM : INT_POS_LIM);
  assign len_ovf = acc_x10 > LEN_LIM;

  // Nesting limit is the smaller of the register and the stack depth
  assign at_limit = (level_q >= LVL_MAX) || (CW'(level_q) >= CW'(max_nesting_q));

  assign lvl_m1 = level_q - LVL_ONE;
  assign lvl_m3 = level_q - LVL_THREE;
  assign top_after = act.pop ? below_q : top_q;

  // Decode the byte against the current mode
  always_comb begin
    act = '0;
    act.kind = EV_NONE;
    act.err  = ERR_NONE;
    act.push_kind = KIND_LIST;
    case (mode_q)
      MODE_VALUE: begin
        if (b == CH_INT) begin
          act.int_begin = 1'b1;
        end else if (is_dig) begin
          act.len_begin = 1'b1;
        end else if (b == CH_LIST || b == CH_DICT) begin
          if (at_limit) begin
            act.fail = 1'b1;
            act.kind = EV_ERR;
            act.err  = ERR_DEEP;
          end else begin
            act.push      = 1'b1;
            act.push_kind = (b == CH_LIST) ? KIND_LIST : KIND_DICT_KEY;
            act.kind      = (b == CH_LIST) ? EV_LIST : EV_DICT;
          end
        end else if (b == CH_END && level_q != '0 && top_q == KIND_LIST) begin
          act.pop  = 1'b1;
          act.fin  = 1'b1;
          act.kind = EV_CLOSE;
        end else begin
          act.fail = 1'b1;
          act.kind = EV_ERR;
          act.err  = ERR_START;
        end
      end
      MODE_KEY: begin
        if (is_dig) begin
          act.len_begin = 1'b1;
          act.len_key   = 1'b1;
        end else if (b == CH_END) begin
          act.pop  = 1'b1;
          act.fin  = 1'b1;
          act.kind = EV_CLOSE;
        end else begin
          act.fail = 1'b1;
          act.kind = EV_ERR;
          act.err  = ERR_KEY;
        end
      end
      MODE_INT_START: begin
        if (b == CH_MINUS && !neg_q) begin
          act.set_neg = 1'b1;
        end else if (b == CH_0 && !neg_q) begin
          act.set_lz = 1'b1;
        end else if (is_dig && b != CH_0) begin
          act.mag_digit = 1'b1;
        end else begin
          // covers negative zero, a second sign and non-digits
          act.fail = 1'b1;
          act.kind = EV_ERR;
          act.err  = ERR_INT;
        end
      end
      MODE_INT_DIGITS: begin
        if (is_dig) begin
          if (lz_q) begin
            act.fail = 1'b1;
            act.kind = EV_ERR;
            act.err  = ERR_INT;
          end else if (int_ovf) begin
            act.fail = 1'b1;
            act.kind = EV_ERR;
            act.err  = ERR_INT_OVF;
          end else begin
            act.mag_step = 1'b1;
          end
        end else if (b == CH_END) begin
          act.kind = EV_INT;
          act.fin  = 1'b1;
        end else begin
          act.fail = 1'b1;
          act.kind = EV_ERR;
          act.err  = ERR_INT;
        end
      end
      MODE_LEN: begin
        if (is_dig) begin
          if (len_ovf) begin
            act.fail = 1'b1;
            act.kind = EV_ERR;
            act.err  = ERR_LEN_OVF;
          end else begin
            act.mag_step = 1'b1;
          end
        end else if (b == CH_COLON) begin
          act.kind = EV_HDR;
          act.hdr  = 1'b1;
          if (mag_q == '0) begin
            act.last    = 1'b1;
            act.key_end = for_key_q;
            act.fin     = !for_key_q;
          end
        end else begin
          act.fail = 1'b1;
          act.kind = EV_ERR;
          act.err  = ERR_LEN;
        end
      end
      MODE_STR: begin
        act.kind     = EV_BYTE;
        act.str_byte = 1'b1;
        if (rem_q <= REM_ONE) begin
          act.last    = 1'b1;
          act.key_end = for_key_q;
          act.fin     = !for_key_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Next parser state
  always_comb begin
    mode_step  = mode_q;
    level_step = level_q;
    top_d      = top_q;
    mag_d      = mag_q;
    neg_d      = neg_q;
    lz_d       = lz_q;
    rem_d      = rem_q;
    for_key_d  = for_key_q;
    if (act.fail) mode_step = MODE_ERROR;
    if (act.int_begin) begin
      mag_d     = '0;
      neg_d     = 1'b0;
      lz_d      = 1'b0;
      mode_step = MODE_INT_START;
    end
    if (act.set_neg) neg_d = 1'b1;
    if (act.set_lz) begin
      lz_d      = 1'b1;
      mag_d     = '0;
      mode_step = MODE_INT_DIGITS;
    end
    if (act.mag_digit) begin
      mag_d     = {60'd0, dig_val};
      mode_step = MODE_INT_DIGITS;
    end
    if (act.mag_step) mag_d = acc_x10[63:0];
    if (act.len_begin) begin
      mag_d     = {60'd0, dig_val};
      for_key_d = act.len_key;
      mode_step = MODE_LEN;
    end
    if (act.hdr) begin
      rem_d     = mag_q[LENGTH_BITS-1:0];
      mode_step = MODE_STR;
    end
    if (act.str_byte) rem_d = rem_q - REM_ONE;
    if (act.push) begin
      level_step = level_q + LVL_ONE;
      top_d      = act.push_kind;
      mode_step  = (act.push_kind == KIND_LIST) ? MODE_VALUE : MODE_KEY;
    end
    if (act.pop) begin
      level_step = lvl_m1;
      top_d      = below_q;
    end
    if (act.key_end) begin
      top_d     = KIND_DICT_VAL;
      mode_step = MODE_VALUE;
    end
    // A finished value either ends the message or advances the container
    if (act.fin) begin
      if (level_step == '0) begin
        mode_step = MODE_DONE;
      end else if (top_after == KIND_DICT_VAL) begin
        top_d     = KIND_DICT_KEY;
        mode_step = MODE_KEY;
      end else begin
        mode_step = MODE_VALUE;
      end
    end
    // End of buffer restarts the parser
    if (eod) begin
      mode_d    = MODE_VALUE;
      level_d   = '0;
      mag_d     = '0;
      neg_d     = 1'b0;
      lz_d      = 1'b0;
      rem_d     = '0;
      for_key_d = 1'b0;
    end else begin
      mode_d  = mode_step;
      level_d = level_step;
    end
  end

  assign eod_fail = eod && mode_step != MODE_DONE && mode_step != MODE_ERROR;

  // Form the result word
  always_comb begin
    res_c = '0;
    res_c.nesting_depth = DEPTH_W'(level_step);
    if (eod_fail) begin
      res_c.event_kind = EV_ERR;
      res_c.error_code = ERR_TRUNCATED;
    end else begin
      res_c.event_kind     = act.kind;
      res_c.error_code     = act.err;
      res_c.last_of_string = act.last;
      res_c.message_done   = act.fin && level_step == '0;
      if (act.kind == EV_INT) res_c.int_value = neg_q ? (64'd0 - mag_q) : mag_q;
      if (act.kind == EV_HDR) res_c.string_length = mag_q[31:0];
      if (act.kind == EV_BYTE) res_c.string_byte = b;
      res_c.is_key = (act.kind == EV_HDR || act.kind == EV_BYTE) && for_key_q;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_nesting_q <= MAX_NESTING_RST;
    end else if (cfg_wr_en_i) begin
      max_nesting_q <= cfg_wr_data_i;
    end
  end

  // Parser state, advanced on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_VALUE;
      level_q   <= '0;
      top_q     <= KIND_NONE;
      mag_q     <= '0;
      neg_q     <= 1'b0;
      lz_q      <= 1'b0;
      rem_q     <= '0;
      for_key_q <= 1'b0;
    end else if (in_accept) begin
      mode_q    <= mode_d;
      level_q   <= level_d;
      top_q     <= top_d;
      mag_q     <= mag_d;
      neg_q     <= neg_d;
      lz_q      <= lz_d;
      rem_q     <= rem_d;
      for_key_q <= for_key_d;
    end
  end

  // Stack memory: push the old top, keep the entry under the new top ready
  always_ff @(posedge clk_i) begin
    if (in_accept && act.push && level_q != '0) begin
      stack_mem[lvl_m1[AW-1:0]] <= top_q;
    end
    if (in_accept && act.push) begin
      below_q <= top_q;
    end else if (in_accept && act.pop && !eod && level_q >= LVL_THREE) begin
      below_q <= stack_mem[lvl_m3[AW-1:0]];
    end
  end

  // Output register with one skid word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take || !out_valid_q) begin
      out_valid_q  <= skid_valid_q || in_accept;
      skid_valid_q <= 1'b0;
    end else if (in_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : res_c;
    end else if (in_accept) begin
      skid_q <= res_c;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Skid word is only held behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held while output register empty");

  // Stack level stays within the stack
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LVL_MAX)
    else $error("stack level beyond stack depth");

  // End of buffer restarts the parser
  a_eod_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && eod) |=> (mode_q == MODE_VALUE && level_q == '0))
    else $error("parser not restarted after end of buffer");

  // String body always has bytes left
  a_str_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_STR) |-> (rem_q != '0))
    else $error("string body with no bytes remaining");

  // Error events carry a code
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.event_kind == EV_ERR) |-> (out_q.error_code != ERR_NONE))
    else $error("error event without error code");

endmodule

### verif/tb_top.sv
// Testbench for the bencode stream tokenizer: byte stimulus, event prediction, result checks.
`timescale 1ns / 1ps

module tb_top;
  import bst_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned STACK_SLOTS = 32;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [5:0] cfg_wr_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  bst_in_t    in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  bst_out_t   out_word;

  bencode_stream_tokenizer_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_wr_data_i (cfg_wr_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .in_data_i     (in_word),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_o    (out_word)
  );

  // Shared testbench state
  bst_out_t    pending_events[$];
  logic [7:0]  msg_bytes[$];
  int unsigned bytes_sent = 0;
  int unsigned fails = 0;
  bit          idle_on = 1'b0;
  logic        long_hold = 1'b0;
  int unsigned stall_left = 0;
  bst_out_t    want;
  event        hold_request;

  // Tokenizer state mirror
  mode_e       p_mode;
  kind_e       p_kinds[STACK_SLOTS];
  int unsigned p_level;
  logic [63:0] p_mag;
  logic        p_neg;
  logic        p_lead0;
  logic        p_for_key;
  logic [31:0] p_remain;
  logic [5:0]  nest_limit = MAX_NESTING_RST;
  bst_out_t    tok_ev;

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Give up if the run stalls
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** bencode_stream_tokenizer_unit: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Event prediction
  // ---------------------------------------------------------------------

  function automatic void clear_parser();
    p_mode    = MODE_VALUE;
    p_level   = 0;
    p_mag     = '0;
    p_neg     = 1'b0;
    p_lead0   = 1'b0;
    p_for_key = 1'b0;
    p_remain  = '0;
  endfunction

  function automatic kind_e top_kind();
    if (p_level == 0) return KIND_NONE;
    return p_kinds[p_level-1];
  endfunction

  function automatic void raise_error(err_e code);
    tok_ev            = '0;
    tok_ev.event_kind = EV_ERR;
    tok_ev.error_code = code;
    p_mode            = MODE_ERROR;
  endfunction

  // Advance the enclosing container, or end the message, once a value is complete
  function automatic void value_complete();
    if (p_level == 0) begin
      tok_ev.message_done = 1'b1;
      p_mode              = MODE_DONE;
    end else if (top_kind() == KIND_DICT_VAL) begin
      p_kinds[p_level-1] = KIND_DICT_KEY;
      p_mode             = MODE_KEY;
    end else begin
      p_mode = MODE_VALUE;
    end
  endfunction

  function automatic void string_complete();
    if (p_for_key) begin
      p_kinds[p_level-1] = KIND_DICT_VAL;
      p_mode             = MODE_VALUE;
    end else begin
      value_complete();
    end
  endfunction

  function automatic void open_level(kind_e k);
    logic [5:0] eff;
    eff = (nest_limit < 6'd32) ? nest_limit : 6'd32;
    if (p_level >= eff) begin
      raise_error(ERR_DEEP);
      return;
    end
    p_kinds[p_level]  = k;
    p_level++;
    tok_ev.event_kind = (k == KIND_LIST) ? EV_LIST : EV_DICT;
    p_mode            = (k == KIND_LIST) ? MODE_VALUE : MODE_KEY;
  endfunction

  function automatic void close_level();
    p_level--;
    tok_ev.event_kind = EV_CLOSE;
    value_complete();
  endfunction

  function automatic void start_length(logic [3:0] d, logic for_key);
    p_mag     = 64'(d);
    p_for_key = for_key;
    p_mode    = MODE_LEN;
  endfunction

  // Advance the mirror by one byte and return the event word it causes
  function automatic bst_out_t tokenize_byte(logic [7:0] b, logic eod);
    logic        is_dig;
    logic [3:0]  d;
    logic [63:0] lim;
    logic [5:0]  depth;
    tok_ev = '0;
    is_dig = (b >= CH_0) && (b <= CH_9);
    d      = b[3:0];
    case (p_mode)
      MODE_VALUE: begin
        if (b == CH_INT) begin
          p_mag   = '0;
          p_neg   = 1'b0;
          p_lead0 = 1'b0;
          p_mode  = MODE_INT_START;
        end else if (is_dig) begin
          start_length(d, 1'b0);
        end else if (b == CH_LIST) begin
          open_level(KIND_LIST);
        end else if (b == CH_DICT) begin
          open_level(KIND_DICT_KEY);
        end else if (b == CH_END && top_kind() == KIND_LIST) begin
          close_level();
        end else begin
          raise_error(ERR_START);
        end
      end
      MODE_KEY: begin
        if (is_dig) start_length(d, 1'b1);
        else if (b == CH_END) close_level();
        else raise_error(ERR_KEY);
      end
      MODE_INT_START: begin
        if (b == CH_MINUS && !p_neg) begin
          p_neg = 1'b1;
        end else if (b == CH_0) begin
          if (p_neg) begin
            raise_error(ERR_INT);
          end else begin
            p_lead0 = 1'b1;
            p_mag   = '0;
            p_mode  = MODE_INT_DIGITS;
          end
        end else if (is_dig) begin
          p_mag  = 64'(d);
          p_mode = MODE_INT_DIGITS;
        end else begin
          raise_error(ERR_INT);
        end
      end
      MODE_INT_DIGITS: begin
        if (is_dig) begin
          lim = p_neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
          if (p_lead0) raise_error(ERR_INT);
          else if (p_mag > (lim - 64'(d)) / 64'd10) raise_error(ERR_INT_OVF);
          else p_mag = p_mag * 64'd10 + 64'(d);
        end else if (b == CH_END) begin
          tok_ev.event_kind = EV_INT;
          tok_ev.int_value  = p_neg ? -p_mag : p_mag;
          value_complete();
        end else begin
          raise_error(ERR_INT);
        end
      end
      MODE_LEN: begin
        if (is_dig) begin
          lim = 64'h0000_0000_ffff_ffff;
          if (p_mag > (lim - 64'(d)) / 64'd10) raise_error(ERR_LEN_OVF);
          else p_mag = p_mag * 64'd10 + 64'(d);
        end else if (b == CH_COLON) begin
          tok_ev.event_kind    = EV_HDR;
          tok_ev.string_length = p_mag[31:0];
          tok_ev.is_key        = p_for_key;
          p_remain             = p_mag[31:0];
          if (p_remain == 0) begin
            tok_ev.last_of_string = 1'b1;
            string_complete();
          end else begin
            p_mode = MODE_STR;
          end
        end else begin
          raise_error(ERR_LEN);
        end
      end
      MODE_STR: begin
        tok_ev.event_kind  = EV_BYTE;
        tok_ev.string_byte = b;
        tok_ev.is_key      = p_for_key;
        if (p_remain != 0) p_remain--;
        if (p_remain == 0) begin
          tok_ev.last_of_string = 1'b1;
          string_complete();
        end
      end
      default: ;
    endcase
    depth = p_level[5:0];
    // An unfinished message at the end flag turns into a truncation error
    if (eod) begin
      if (p_mode != MODE_DONE && p_mode != MODE_ERROR) raise_error(ERR_TRUNCATED);
      clear_parser();
    end
    tok_ev.nesting_depth = depth;
    return tok_ev;
  endfunction

  // ---------------------------------------------------------------------
  // Output side: stall pattern and checking
  // ---------------------------------------------------------------------

  // Hold the output for a long stretch on request
  initial begin
    forever begin
      @(hold_request);
      @(posedge clk);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      long_hold <= 1'b0;
    end
  end

  // Stall the output in short random bursts
  always @(posedge clk) begin
    if (long_hold) begin
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected event word %h", out_word);
      end else begin
        want = pending_events.pop_front();
        if (out_word.event_kind     !== want.event_kind     ||
            out_word.int_value      !== want.int_value      ||
            out_word.string_length  !== want.string_length  ||
            out_word.string_byte    !== want.string_byte    ||
            out_word.is_key         !== want.is_key         ||
            out_word.last_of_string !== want.last_of_string ||
            out_word.nesting_depth  !== want.nesting_depth  ||
            out_word.message_done   !== want.message_done   ||
            out_word.error_code     !== want.error_code) begin
          fails++;
          if (fails <= 10) begin
            $display("mismatch (expected/actual): kind %0d/%0d int %0d/%0d len %0d/%0d",
                     want.event_kind, out_word.event_kind, want.int_value,
                     out_word.int_value, want.string_length, out_word.string_length);
            $display("  byte %h/%h key %b/%b last %b/%b depth %0d/%0d done %b/%b err %0d/%0d",
                     want.string_byte, out_word.string_byte, want.is_key, out_word.is_key,
                     want.last_of_string, out_word.last_of_string, want.nesting_depth,
                     out_word.nesting_depth, want.message_done, out_word.message_done,
                     want.error_code, out_word.error_code);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Append one byte to the staged message
  function automatic void add_byte(logic [7:0] v);
    msg_bytes.insert(msg_bytes.size(), v);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // Offer one word, maybe after a short gap, and record its prediction
  task automatic send_byte(input logic [7:0] b, input logic eod);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{data_byte: b, end_of_data: eod};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_events.insert(pending_events.size(), tokenize_byte(b, eod));
    bytes_sent++;
  endtask

  // Send the staged message with the end flag on its last byte
  task automatic send_msg();
    for (int i = 0; i < msg_bytes.size(); i++) begin
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    msg_bytes.delete();
    push_text(s);
    send_msg();
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_events.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_nesting(input logic [5:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    nest_limit   = v;
  endtask

  // ---------------------------------------------------------------------
  // Message generation
  // ---------------------------------------------------------------------

  // Half syntax characters, half anything
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 15))
      0:       return CH_INT;
      1:       return CH_LIST;
      2:       return CH_DICT;
      3:       return CH_END;
      4:       return CH_COLON;
      5:       return CH_MINUS;
      6:       return CH_0;
      7:       return CH_9;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void gen_int();
    longint v;
    case ($urandom_range(0, 5))
      0:       v = 0;
      1:       v = $urandom_range(1, 999);
      2:       v = -longint'($urandom_range(1, 999));
      3:       v = 64'sh7fff_ffff_ffff_ffff;
      4:       v = 64'sh8000_0000_0000_0000;
      default: v = {$urandom, $urandom};
    endcase
    push_text($sformatf("i%0de", v));
  endfunction

  function automatic void gen_string();
    int unsigned len;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 4);
    if ($urandom_range(0, 4) == 0) push_text($sformatf("0%0d:", len));
    else push_text($sformatf("%0d:", len));
    repeat (len) add_byte(8'($urandom_range(0, 255)));
  endfunction

  // Build one well-formed value nested at most lvl deep
  function automatic void gen_value(int unsigned lvl);
    int unsigned n;
    n = $urandom_range(0, 3);
    case ($urandom_range(0, (lvl != 0) ? 4 : 2))
      0: gen_int();
      1, 2: gen_string();
      3: begin
        add_byte(CH_LIST);
        repeat (n) gen_value(lvl - 1);
        add_byte(CH_END);
      end
      default: begin
        add_byte(CH_DICT);
        repeat (n) begin
          gen_string();
          gen_value(lvl - 1);
        end
        add_byte(CH_END);
      end
    endcase
  endfunction

  // Mostly clean messages, some cut short, corrupted, padded or pure noise
  task automatic random_message();
    int unsigned pick;
    int unsigned keep;
    msg_bytes.delete();
    pick = $urandom_range(0, 9);
    if (pick == 9) begin
      repeat ($urandom_range(1, 6)) add_byte(pick_byte());
    end else begin
      gen_value($urandom_range(0, 3));
      if (pick == 6 && msg_bytes.size() > 1) begin
        keep = $urandom_range(1, msg_bytes.size() - 1);
        while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
      end else if (pick == 7) begin
        msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = pick_byte();
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 3)) add_byte(pick_byte());
      end
    end
    send_msg();
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Field extremes, every event kind and every error code but the nesting limit error
  task automatic test_directed();
    send_text("i0e");
    send_text("i-0e");
    send_text("i042e");
    send_text("ie");
    send_text("i--1e");
    send_text("i9223372036854775807e");
    send_text("i-9223372036854775808e");
    send_text("i9223372036854775808e");
    send_text("i-9223372036854775809e");
    send_text("0:");
    send_text("003:abc");
    send_text("4294967295:");
    send_text("4294967296:");
    send_text("3x");
    send_text("e");
    send_text("d1:ae");
    send_text("di1ee");
    send_text("le");
    send_text("de");
    send_text("li1e4:spame");
    send_text("d3:keyl1:xee");
    send_text("i7eXYZ");
    send_text("x");
    send_text("l");
    drain();
  endtask

  // Nesting limit at zero, one, above the stack size and at the stack size
  task automatic test_nesting_limit();
    set_nesting(6'd0);
    send_text("le");
    send_text("de");
    send_text("i1e");
    drain();
    set_nesting(6'd1);
    send_text("le");
    send_text("lle");
    send_text("d1:ade");
    drain();
    set_nesting(6'd63);
    msg_bytes.delete();
    repeat (STACK_SLOTS) add_byte(CH_LIST);
    repeat (STACK_SLOTS) add_byte(CH_END);
    send_msg();
    msg_bytes.delete();
    repeat (STACK_SLOTS + 1) add_byte(CH_LIST);
    send_msg();
    drain();
    set_nesting(6'd32);
    msg_bytes.delete();
    repeat (STACK_SLOTS) add_byte(CH_DICT);
    send_msg();
    drain();
  endtask

  // Keep offering words while the output is held off
  task automatic test_long_stall();
    idle_on = 1'b0;
    -> hold_request;
    repeat (12) random_message();
    drain();
  endtask

  task automatic test_random(input int unsigned target, input bit with_idle);
    int unsigned goal;
    int unsigned next_cfg;
    idle_on  = with_idle;
    goal     = bytes_sent + target;
    next_cfg = bytes_sent + 250;
    while (bytes_sent < goal) begin
      // Change the limit between phases once idle
      if (bytes_sent >= next_cfg) begin
        drain();
        case ($urandom_range(0, 5))
          0:       set_nesting(6'd0);
          1:       set_nesting(6'd32);
          2:       set_nesting(6'd63);
          3:       set_nesting(6'($urandom_range(0, 63)));
          default: set_nesting(6'($urandom_range(1, 4)));
        endcase
        idle_on  = with_idle && ($urandom_range(0, 3) != 0);
        next_cfg = bytes_sent + 250;
      end
      random_message();
    end
    drain();
  endtask

  initial begin
    clear_parser();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_nesting_limit();
    test_long_stall();
    test_random(900, 1'b1);
    test_random(300, 1'b0);
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("** bencode_stream_tokenizer_unit: PASSED **");
    end else begin
      $display("** bencode_stream_tokenizer_unit: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
design/bst_pkg.sv
design/bencode_stream_tokenizer_unit.sv
verif/tb_top.sv
